// ----- sv/i2cms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and codes of the i2c master transaction sequencer
// Holds the operation and bus status codes, the command codes of the result
// stream, and the records passed from the front end to the output stage.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	// default sizing
	localparam int DEF_QUEUE_DEPTH = 8;
	localparam int DEF_MAX_LENGTH  = 255;

	// input operation codes
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_EVENT   = 1'b1;

	// byte controller status codes
	localparam logic [7:0] ST_START_SENT   = 8'h08;
	localparam logic [7:0] ST_RSTART_SENT  = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK    = 8'h20;
	localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST     = 8'h38;
	localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK    = 8'h48;
	localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

	// commands carried in the result stream
	typedef enum logic [3:0] {
		ACT_NONE   = 4'd0,
		ACT_ACCEPT = 4'd1,
		ACT_REJECT = 4'd2,
		ACT_START  = 4'd3,
		ACT_ADDR   = 4'd4,
		ACT_TX     = 4'd5,
		ACT_RX     = 4'd6,
		ACT_ACK    = 4'd7,
		ACT_NACK   = 4'd8,
		ACT_STOP   = 4'd9,
		ACT_RSTART = 4'd10,
		ACT_DONE   = 4'd11,
		ACT_IDLE   = 4'd12
	} action_t;

	// one queued transaction
	typedef struct packed {
		logic [6:0] addr;
		logic       rnw;
		logic [7:0] len;
		logic       rep;
		logic [7:0] handle;
	} txn_t;

	// one result of a transaction step
	typedef struct packed {
		action_t    action;
		logic [7:0] bus_byte;
		logic [7:0] handle;
		logic [7:0] index;
		logic [7:0] status;
	} result_t;

	// all results of one input transaction
	typedef struct packed {
		result_t [3:0] res;
		logic [1:0]    n_last;
		logic [3:0]    level;
	} step_t;

	function automatic result_t mk_res(action_t a, logic [7:0] b, logic [7:0] h,
		logic [7:0] idx, logic [7:0] st);
		result_t r;
		r.action   = a;
		r.bus_byte = b;
		r.handle   = h;
		r.index    = idx;
		r.status   = st;
		return r;
	endfunction

endpackage

// ----- sv/i2c_master_transaction_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer: queued i2c master transaction stepping
// Queues transactions and turns byte controller status events into commands.
// ----------------------------------------------------------------------------
// Each input transaction (an enqueue or a bus status event) is taken by the
// decoder, which updates the queue and byte count and produces one to four
// commands; the output stage then presents them one per cycle while the
// result side does not stall, the last one flagged. A two-entry step queue
// sits between the two, so new input is taken while earlier commands still
// wait at the output. An input that stores a transaction behind the head, or
// pops to the next one, stalls the input side while the registered read of
// the backing store catches up, so the input rate is one per cycle only
// between such inputs and while the step queue has room, and the sustained
// rate is bounded by the output side at one command per cycle (up to four
// commands for an ending transaction). There is no clearing pass after reset.
module i2c_master_transaction_sequencer import i2cms_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int MAX_LENGTH  = DEF_MAX_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       operation,
	input  logic [6:0] device_address,
	input  logic       read_not_write,
	input  logic [7:0] transfer_length,
	input  logic       repeat_start,
	input  logic [7:0] buffer_handle,
	input  logic [7:0] bus_status,
	input  logic [7:0] rx_byte,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [3:0] action,
	output logic [7:0] bus_byte,
	output logic [7:0] out_handle,
	output logic [7:0] buffer_index,
	output logic [7:0] completion_status,
	output logic [3:0] queue_level,
	output logic       last
);

	logic  push, fifo_full, fifo_valid, pop;
	step_t push_data, pop_data;

	// decoder and transaction queue
	i2cms_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MAX_LENGTH (MAX_LENGTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.operation      (operation),
		.device_address (device_address),
		.read_not_write (read_not_write),
		.transfer_length(transfer_length),
		.repeat_start   (repeat_start),
		.buffer_handle  (buffer_handle),
		.bus_status     (bus_status),
		.rx_byte        (rx_byte),
		.fifo_full      (fifo_full),
		.push           (push),
		.push_data      (push_data)
	);

	// step record queue
	i2cms_step_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (fifo_full),
		.pop      (pop),
		.valid    (fifo_valid),
		.pop_data (pop_data)
	);

	// command serializer
	i2cms_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_valid       (fifo_valid),
		.step_data        (pop_data),
		.pop              (pop),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.action           (action),
		.bus_byte         (bus_byte),
		.out_handle       (out_handle),
		.buffer_index     (buffer_index),
		.completion_status(completion_status),
		.queue_level      (queue_level),
		.last             (last)
	);

endmodule

// ----- sv/i2cms_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_front: transaction queue and bus status decoder
// Accepts at most one transaction per cycle, updates the queue and byte count,
// and emits the full list of commands of that transaction as one step record.
// ----------------------------------------------------------------------------
module i2cms_front import i2cms_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int MAX_LENGTH  = DEF_MAX_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       operation,
	input  logic [6:0] device_address,
	input  logic       read_not_write,
	input  logic [7:0] transfer_length,
	input  logic       repeat_start,
	input  logic [7:0] buffer_handle,
	input  logic [7:0] bus_status,
	input  logic [7:0] rx_byte,
	input  logic       fifo_full,
	output logic       push,
	output step_t      push_data
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LenCap = (MAX_LENGTH > 255) ? 255 : MAX_LENGTH;
	localparam logic [7:0] LEN_CAP = 8'(LenCap);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [CNT_W-1:0] count_q, count_n;
	logic [7:0]       bc_q, bc_n, bc_inc;
	txn_t             head_q, head_new, new_txn, rd_data_q;
	txn_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_inc, rd_ptr_inc;
	logic             stale_q;
	logic             acc;
	logic             head_load, mem_we, rd_adv, fin_c, fin_end_c;
	logic [2:0]       n_c;
	step_t            step_c;

	// stall while the registered store read catches up after a write or pop
	assign req_stall = fifo_full | stale_q;
	assign acc       = req_valid & ~req_stall;
	assign push      = acc;
	assign push_data = step_c;

	// incoming transaction record with length capped
	always_comb begin
		new_txn.addr   = device_address;
		new_txn.rnw    = read_not_write;
		new_txn.len    = (transfer_length > LEN_CAP) ? LEN_CAP : transfer_length;
		new_txn.rep    = repeat_start;
		new_txn.handle = buffer_handle;
	end

	assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
	assign bc_inc     = (bc_q == 8'hFF) ? bc_q : bc_q + 8'd1;

	// decode the transaction into its command list and next state
	always_comb begin
		step_c    = '0;
		n_c       = 3'd0;
		fin_c     = 1'b0;
		fin_end_c = 1'b0;
		count_n   = count_q;
		bc_n      = bc_q;
		head_load = 1'b0;
		head_new  = new_txn;
		mem_we    = 1'b0;
		rd_adv    = 1'b0;
		if (operation == OP_ENQUEUE) begin
			if (count_q == CNT_FULL) begin
				step_c.res[n_c[1:0]] = mk_res(ACT_REJECT, 8'd0, buffer_handle, 8'd0, 8'd0);
				n_c = n_c + 3'd1;
			end else begin
				count_n = count_q + 1'b1;
				step_c.res[n_c[1:0]] = mk_res(ACT_ACCEPT, 8'd0, buffer_handle, 8'd0, 8'd0);
				n_c = n_c + 3'd1;
				if (count_q == '0) begin
					head_load = 1'b1;
					bc_n      = 8'd0;
					step_c.res[n_c[1:0]] = mk_res(ACT_START, 8'd0, buffer_handle, 8'd0, 8'd0);
					n_c = n_c + 3'd1;
				end else begin
					mem_we = 1'b1;
				end
			end
		end else if (count_q == '0) begin
			step_c.res[n_c[1:0]] = mk_res(ACT_NONE, 8'd0, 8'd0, 8'd0, 8'd0);
			n_c = n_c + 3'd1;
		end else begin
			unique case (bus_status)
				ST_START_SENT, ST_RSTART_SENT: begin
					step_c.res[n_c[1:0]] = mk_res(ACT_ADDR, {head_q.addr, head_q.rnw},
						head_q.handle, 8'd0, 8'd0);
					n_c = n_c + 3'd1;
				end
				ST_SLAW_ACK, ST_DATA_TX_ACK: begin
					if (bc_q == head_q.len) begin
						fin_c     = 1'b1;
						fin_end_c = 1'b1;
					end else begin
						step_c.res[n_c[1:0]] = mk_res(ACT_TX, 8'd0, head_q.handle, bc_q, 8'd0);
						n_c  = n_c + 3'd1;
						bc_n = bc_inc;
					end
				end
				ST_SLAW_NACK, ST_DATA_TX_NACK, ST_SLAR_NACK: begin
					fin_c     = 1'b1;
					fin_end_c = 1'b1;
				end
				ST_ARB_LOST: begin
					step_c.res[n_c[1:0]] = mk_res(ACT_START, 8'd0, head_q.handle, 8'd0, 8'd0);
					n_c = n_c + 3'd1;
				end
				ST_SLAR_ACK: begin
					step_c.res[n_c[1:0]] = mk_res(
						({1'b0, head_q.len} <= {1'b0, bc_q} + 9'd1) ? ACT_NACK : ACT_ACK,
						8'd0, head_q.handle, 8'd0, 8'd0);
					n_c = n_c + 3'd1;
				end
				ST_DATA_RX_ACK: begin
					step_c.res[n_c[1:0]] = mk_res(ACT_RX, rx_byte, head_q.handle, bc_q, 8'd0);
					n_c  = n_c + 3'd1;
					bc_n = bc_inc;
					step_c.res[n_c[1:0]] = mk_res(
						({1'b0, head_q.len} == {1'b0, bc_inc} + 9'd1) ? ACT_NACK : ACT_ACK,
						8'd0, head_q.handle, 8'd0, 8'd0);
					n_c = n_c + 3'd1;
				end
				ST_DATA_RX_NACK: begin
					step_c.res[n_c[1:0]] = mk_res(ACT_RX, rx_byte, head_q.handle, bc_q, 8'd0);
					n_c       = n_c + 3'd1;
					fin_c     = 1'b1;
					fin_end_c = 1'b1;
				end
				default: begin
					fin_c = 1'b1;
				end
			endcase
		end
		// ending of the head transaction: optional stop or repeated start, done, then next start or idle
		if (fin_c) begin
			if (fin_end_c) begin
				step_c.res[n_c[1:0]] = mk_res(head_q.rep ? ACT_RSTART : ACT_STOP, 8'd0,
					head_q.handle, 8'd0, 8'd0);
				n_c = n_c + 3'd1;
			end
			step_c.res[n_c[1:0]] = mk_res(ACT_DONE, 8'd0, head_q.handle, 8'd0, bus_status);
			n_c     = n_c + 3'd1;
			count_n = count_q - 1'b1;
			if (count_q > CNT_W'(1)) begin
				head_load = 1'b1;
				head_new  = rd_data_q;
				rd_adv    = 1'b1;
				bc_n      = 8'd0;
				step_c.res[n_c[1:0]] = mk_res(ACT_START, 8'd0, rd_data_q.handle, 8'd0, 8'd0);
				n_c = n_c + 3'd1;
			end else begin
				step_c.res[n_c[1:0]] = mk_res(ACT_IDLE, 8'd0, 8'd0, 8'd0, 8'd0);
				n_c = n_c + 3'd1;
			end
		end
		step_c.n_last = n_c[1:0] - 2'd1;
		step_c.level  = 4'(count_n);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			bc_q     <= 8'd0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			stale_q  <= 1'b0;
		end else begin
			stale_q <= acc & (mem_we | rd_adv);
			if (acc) begin
				count_q <= count_n;
				bc_q    <= bc_n;
				if (mem_we) begin
					wr_ptr_q <= wr_ptr_inc;
				end
				if (rd_adv) begin
					rd_ptr_q <= rd_ptr_inc;
				end
			end
		end
	end

	// head transaction register
	always_ff @(posedge clk) begin
		if (acc && head_load) begin
			head_q <= head_new;
		end
	end

	// backing store for the transactions behind the head
	always_ff @(posedge clk) begin
		if (acc && mem_we) begin
			mem_q[wr_ptr_q] <= new_txn;
		end
		rd_data_q <= mem_q[rd_ptr_q];
	end

endmodule

// ----- sv/i2cms_step_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_step_fifo: two-entry queue of step records
// Decouples the decoder from the output stage so each side stalls on its own.
// ----------------------------------------------------------------------------
module i2cms_step_fifo import i2cms_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  step_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output step_t pop_data
);

	step_t      slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign valid    = (cnt_q != 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- sv/i2cms_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_back: result serializer
// Walks the commands of a step record one per cycle, while the result side does not stall, into the output register.
// ----------------------------------------------------------------------------
module i2cms_back import i2cms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_valid,
	input  step_t      step_data,
	output logic       pop,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [3:0] action,
	output logic [7:0] bus_byte,
	output logic [7:0] out_handle,
	output logic [7:0] buffer_index,
	output logic [7:0] completion_status,
	output logic [3:0] queue_level,
	output logic       last
);

	logic [1:0] idx_q;
	logic       valid_q;
	result_t    res_q;
	logic [3:0] level_q;
	logic       last_q;
	logic       load, at_last;

	assign load    = step_valid & (~valid_q | ~rsp_stall);
	assign at_last = (idx_q == step_data.n_last);
	assign pop     = load & at_last;

	assign rsp_valid         = valid_q;
	assign action            = res_q.action;
	assign bus_byte          = res_q.bus_byte;
	assign out_handle        = res_q.handle;
	assign buffer_index      = res_q.index;
	assign completion_status = res_q.status;
	assign queue_level       = level_q;
	assign last              = last_q;

	// output valid and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= at_last ? 2'd0 : idx_q + 2'd1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q   <= step_data.res[idx_q];
			level_q <= step_data.level;
			last_q  <= at_last;
		end
	end

endmodule

// ----- sv/i2cms_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_checker: port-level checks of the transaction sequencer
// Watches the result stream for command ordering rules of the sequencer.
// ----------------------------------------------------------------------------
module i2cms_checker import i2cms_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input logic [3:0] action,
	input logic [3:0] queue_level,
	input logic       last
);

	// a stalled result keeps its command and framing
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(action) && $stable(last))
		else $error("result changed while stalled");

	// a rejected enqueue has no further commands
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (action == ACT_REJECT) |-> last)
		else $error("reject not final");

	// done is never the last command; a start or idle always follows it
	a_done_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (action == ACT_DONE) |-> !last)
		else $error("done was final");

	// idle and ignored events leave an empty queue
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && ((action == ACT_IDLE) || (action == ACT_NONE))
			|-> last && (queue_level == 4'd0))
		else $error("idle with nonempty queue");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp_valid),
	.rsp_stall  (rsp_stall),
	.action     (action),
	.queue_level(queue_level),
	.last       (last)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the i2c master transaction sequencer
// Drives enqueue and bus status transactions through the valid/stall request
// channel, predicts every command of the result stream with a behavioral
// model of the queue and byte counter, and compares the results field by
// field. A directed table comes first, then well-formed random transaction
// flows mixed with noise, with a long read run that saturates the byte index.
// ----------------------------------------------------------------------------
module tb;
	import i2cms_pkg::*;

	localparam int QUEUE_DEPTH  = DEF_QUEUE_DEPTH;
	localparam int MAX_LENGTH   = DEF_MAX_LENGTH;
	localparam int TOTAL_ITEMS  = 470;
	localparam int SAT_RUN_AT   = 120;
	localparam int CALM_TAIL    = 60;
	localparam int NUM_DIRECTED = 26;
	localparam logic [7:0] ST_UNKNOWN = 8'hFE;

	localparam logic [7:0] KNOWN_CODES [12] = '{
		ST_START_SENT, ST_RSTART_SENT, ST_SLAW_ACK, ST_SLAW_NACK, ST_DATA_TX_ACK,
		ST_DATA_TX_NACK, ST_ARB_LOST, ST_SLAR_ACK, ST_SLAR_NACK, ST_DATA_RX_ACK,
		ST_DATA_RX_NACK, ST_UNKNOWN
	};

	// one request transaction
	typedef struct packed {
		logic       op;
		logic [6:0] addr;
		logic       rnw;
		logic [7:0] len;
		logic       rep;
		logic [7:0] handle;
		logic [7:0] status;
		logic [7:0] rx;
	} bus_item_t;

	// directed row: request plus first command typed in where obvious
	typedef struct packed {
		bus_item_t  it;
		logic       pinned;
		action_t    act;
		logic [3:0] lvl;
	} dir_row_t;

	// one command of the result stream
	typedef struct packed {
		action_t    act;
		logic [7:0] bus_byte;
		logic [7:0] handle;
		logic [7:0] index;
		logic [7:0] status;
		logic [3:0] level;
		logic       fin;
	} cmd_t;

	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		// status event while nothing is queued
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_START_SENT,   8'h00}, 1'b1, ACT_NONE,   4'd0},
		// top address, read, zero length
		'{'{OP_ENQUEUE, 7'h7F, 1'b1, 8'h00, 1'b0, 8'hFF, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd1},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_START_SENT,   8'h00}, 1'b1, ACT_ADDR,   4'd1},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_SLAR_ACK,     8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_DATA_RX_NACK, 8'hFF}, 1'b1, ACT_RX,     4'd0},
		// fill the queue to its depth
		'{'{OP_ENQUEUE, 7'h00, 1'b0, 8'h02, 1'b1, 8'h00, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd1},
		'{'{OP_ENQUEUE, 7'h55, 1'b1, 8'hFF, 1'b0, 8'h80, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd2},
		'{'{OP_ENQUEUE, 7'h01, 1'b0, 8'h01, 1'b0, 8'h01, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd3},
		'{'{OP_ENQUEUE, 7'h2A, 1'b1, 8'h01, 1'b1, 8'h02, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd4},
		'{'{OP_ENQUEUE, 7'h03, 1'b0, 8'h00, 1'b0, 8'h03, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd5},
		'{'{OP_ENQUEUE, 7'h04, 1'b1, 8'h03, 1'b0, 8'h04, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd6},
		'{'{OP_ENQUEUE, 7'h05, 1'b0, 8'h05, 1'b1, 8'h05, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd7},
		'{'{OP_ENQUEUE, 7'h7E, 1'b1, 8'hFE, 1'b0, 8'hFE, 8'h00,           8'h00}, 1'b1, ACT_ACCEPT, 4'd8},
		// full queue
		'{'{OP_ENQUEUE, 7'h7F, 1'b1, 8'hFF, 1'b1, 8'hAA, 8'h00,           8'h00}, 1'b1, ACT_REJECT, 4'd8},
		// write of two bytes ending with a repeated start
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_RSTART_SENT,  8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_SLAW_ACK,     8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_DATA_TX_ACK,  8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_DATA_TX_ACK,  8'h00}, 1'b0, ACT_NONE,   4'd0},
		// arbitration lost, then a long read cut by an address nack
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_ARB_LOST,     8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_START_SENT,   8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_SLAR_ACK,     8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_DATA_RX_ACK,  8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_SLAR_NACK,    8'h00}, 1'b0, ACT_NONE,   4'd0},
		// nack endings, then an unknown status
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_SLAW_NACK,    8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_DATA_TX_NACK, 8'h00}, 1'b0, ACT_NONE,   4'd0},
		'{'{OP_EVENT,   7'h00, 1'b0, 8'h00, 1'b0, 8'h00, ST_UNKNOWN,      8'h00}, 1'b1, ACT_DONE,   4'd3}
	};

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	logic       operation;
	logic [6:0] device_address;
	logic       read_not_write;
	logic [7:0] transfer_length;
	logic       repeat_start;
	logic [7:0] buffer_handle;
	logic [7:0] bus_status;
	logic [7:0] rx_byte;
	logic       rsp_valid;
	logic       rsp_stall;
	logic [3:0] action;
	logic [7:0] bus_byte;
	logic [7:0] out_handle;
	logic [7:0] buffer_index;
	logic [7:0] completion_status;
	logic [3:0] queue_level;
	logic       last;

	// mirror of the block state
	txn_t       txn_fifo[$];
	logic [7:0] byte_pos;
	cmd_t       cmd_step[4];
	int         cmd_n;
	cmd_t       cmd_expect[$];
	bit         head_changed;

	// run bookkeeping
	int fail_count;
	int n_checked;
	int n_sent;
	int n_rejects;
	int head_phase;
	bit jitter_on;
	bit calm;

	i2c_master_transaction_sequencer DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("%0t: timeout, %0d commands still outstanding", $time, cmd_expect.size());
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void push_cmd(action_t a, logic [7:0] b, logic [7:0] h,
		logic [7:0] idx, logic [7:0] st);
		cmd_step[cmd_n] = '{a, b, h, idx, st, 4'd0, 1'b0};
		cmd_n++;
	endfunction

	// end of the head transaction: optional stop or repeated start, done, then next start or idle
	function automatic void retire_head(bit send_end, logic [7:0] st);
		txn_t h;
		h = txn_fifo[0];
		if (send_end)
			push_cmd(h.rep ? ACT_RSTART : ACT_STOP, 8'h00, h.handle, 8'h00, 8'h00);
		push_cmd(ACT_DONE, 8'h00, h.handle, 8'h00, st);
		void'(txn_fifo.pop_front());
		head_changed = 1'b1;
		if (txn_fifo.size() > 0) begin
			byte_pos = 8'h00;
			push_cmd(ACT_START, 8'h00, txn_fifo[0].handle, 8'h00, 8'h00);
		end else begin
			push_cmd(ACT_IDLE, 8'h00, 8'h00, 8'h00, 8'h00);
		end
	endfunction

	// commands caused by one accepted request
	function automatic void advance_sequencer(bus_item_t it);
		txn_t h;
		txn_t e;
		int   i;
		cmd_n = 0;
		head_changed = 1'b0;
		if (it.op == OP_ENQUEUE) begin
			if (txn_fifo.size() >= QUEUE_DEPTH) begin
				push_cmd(ACT_REJECT, 8'h00, it.handle, 8'h00, 8'h00);
				n_rejects++;
			end else begin
				e.addr   = it.addr;
				e.rnw    = it.rnw;
				e.len    = (int'(it.len) > MAX_LENGTH) ? 8'(MAX_LENGTH) : it.len;
				e.rep    = it.rep;
				e.handle = it.handle;
				txn_fifo.push_back(e);
				push_cmd(ACT_ACCEPT, 8'h00, it.handle, 8'h00, 8'h00);
				if (txn_fifo.size() == 1) begin
					byte_pos = 8'h00;
					head_changed = 1'b1;
					push_cmd(ACT_START, 8'h00, it.handle, 8'h00, 8'h00);
				end
			end
		end else if (txn_fifo.size() == 0) begin
			push_cmd(ACT_NONE, 8'h00, 8'h00, 8'h00, 8'h00);
		end else begin
			h = txn_fifo[0];
			case (it.status)
				ST_START_SENT, ST_RSTART_SENT:
					push_cmd(ACT_ADDR, {h.addr, h.rnw}, h.handle, 8'h00, 8'h00);
				ST_SLAW_ACK, ST_DATA_TX_ACK: begin
					if (byte_pos == h.len) begin
						retire_head(1'b1, it.status);
					end else begin
						push_cmd(ACT_TX, 8'h00, h.handle, byte_pos, 8'h00);
						if (byte_pos != 8'hFF)
							byte_pos++;
					end
				end
				ST_SLAW_NACK, ST_DATA_TX_NACK, ST_SLAR_NACK:
					retire_head(1'b1, it.status);
				ST_ARB_LOST:
					push_cmd(ACT_START, 8'h00, h.handle, 8'h00, 8'h00);
				ST_SLAR_ACK:
					push_cmd((int'(h.len) <= int'(byte_pos) + 1) ? ACT_NACK : ACT_ACK,
						8'h00, h.handle, 8'h00, 8'h00);
				ST_DATA_RX_ACK: begin
					push_cmd(ACT_RX, it.rx, h.handle, byte_pos, 8'h00);
					// index sticks at its top value
					if (byte_pos != 8'hFF)
						byte_pos++;
					push_cmd((int'(h.len) == int'(byte_pos) + 1) ? ACT_NACK : ACT_ACK,
						8'h00, h.handle, 8'h00, 8'h00);
				end
				ST_DATA_RX_NACK: begin
					push_cmd(ACT_RX, it.rx, h.handle, byte_pos, 8'h00);
					retire_head(1'b1, it.status);
				end
				default:
					// unknown status ends the transaction without a stop
					retire_head(1'b0, it.status);
			endcase
		end
		for (i = 0; i < cmd_n; i++) begin
			cmd_step[i].level = 4'(txn_fifo.size());
			cmd_step[i].fin   = (i == cmd_n - 1);
		end
	endfunction

	function automatic bus_item_t event_item(logic [7:0] st);
		bus_item_t   it;
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		it = bits[$bits(bus_item_t)-1:0];
		it.op = OP_EVENT;
		it.status = st;
		return it;
	endfunction

	// mostly well-formed bus flows for the head transaction, some noise
	function automatic bus_item_t next_random_item();
		bus_item_t it;
		txn_t      h;
		int        r;
		int        fill;
		it = event_item(8'h00);
		it.op = 1'($urandom);
		it.status = 8'($urandom);
		r = $urandom_range(0, 99);
		fill = txn_fifo.size();
		if (r < 10) begin
			if (r < 5)
				it.status = KNOWN_CODES[$urandom_range(0, 11)];
			return it;
		end
		if (fill == 0 || (fill < QUEUE_DEPTH && r < 25) || (fill == QUEUE_DEPTH && r < 13)) begin
			it.op = OP_ENQUEUE;
			it.len = (r % 8 == 0) ? 8'($urandom_range(7, 20)) : 8'($urandom_range(0, 6));
			return it;
		end
		it.op = OP_EVENT;
		h = txn_fifo[0];
		r = $urandom_range(0, 19);
		case (head_phase)
			0: begin
				it.status = r[0] ? ST_START_SENT : ST_RSTART_SENT;
				head_phase = 1;
			end
			1: begin
				if (h.rnw) begin
					it.status = (r == 0) ? ST_SLAR_NACK : ST_SLAR_ACK;
					head_phase = 2;
				end else if (r == 0) begin
					it.status = ST_ARB_LOST;
					head_phase = 0;
				end else if (r == 1 || byte_pos > 8'd24) begin
					it.status = (byte_pos == 8'h00) ? ST_SLAW_NACK : ST_DATA_TX_NACK;
				end else begin
					it.status = (byte_pos == 8'h00) ? ST_SLAW_ACK : ST_DATA_TX_ACK;
				end
			end
			default: begin
				if (r == 0) begin
					it.status = ST_ARB_LOST;
					head_phase = 0;
				end else if (r == 1 || byte_pos > 8'd24 || int'(byte_pos) + 1 >= int'(h.len)) begin
					it.status = ST_DATA_RX_NACK;
				end else begin
					it.status = ST_DATA_RX_ACK;
				end
			end
		endcase
		return it;
	endfunction

	// present one request, hold it while stalled, predict on acceptance
	task automatic send_item(bus_item_t it, bit pinned, action_t pin_act, logic [3:0] pin_lvl);
		int i;
		if (jitter_on && !calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_valid       <= 1'b1;
		operation       <= it.op;
		device_address  <= it.addr;
		read_not_write  <= it.rnw;
		transfer_length <= it.len;
		repeat_start    <= it.rep;
		buffer_handle   <= it.handle;
		bus_status      <= it.status;
		rx_byte         <= it.rx;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		advance_sequencer(it);
		if (pinned) begin
			cmd_step[0].act   = pin_act;
			cmd_step[0].level = pin_lvl;
		end
		for (i = 0; i < cmd_n; i++)
			cmd_expect.push_back(cmd_step[i]);
		n_sent++;
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// result side stalls in bursts
	initial begin : rsp_side
		int burst;
		burst = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (burst > 0) begin
				rsp_stall <= 1'b1;
				burst--;
			end else begin
				rsp_stall <= 1'b0;
				if (jitter_on && !calm && $urandom_range(0, 4) == 0)
					burst = $urandom_range(1, 7);
			end
		end
	end

	// compare each accepted command with the oldest prediction
	always @(posedge clk) begin : cmd_monitor
		cmd_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (cmd_expect.size() == 0) begin
				$display("%0t: unexpected command: expected none, actual action %0d handle %0h",
					$time, action, out_handle);
				fail_count++;
			end else begin
				want = cmd_expect.pop_front();
				check_field("action", 8'(want.act), 8'(action));
				check_field("bus_byte", want.bus_byte, bus_byte);
				check_field("out_handle", want.handle, out_handle);
				check_field("buffer_index", want.index, buffer_index);
				check_field("completion_status", want.status, completion_status);
				check_field("queue_level", 8'(want.level), 8'(queue_level));
				check_field("last", 8'(want.fin), 8'(last));
				n_checked++;
			end
		end
	end

	initial begin : stimulus
		bus_item_t it;
		int        k;
		int        n_items;
		bit        sat_done;
		arst_n          <= 1'b0;
		req_valid       <= 1'b0;
		operation       <= OP_ENQUEUE;
		device_address  <= 7'h00;
		read_not_write  <= 1'b0;
		transfer_length <= 8'h00;
		repeat_start    <= 1'b0;
		buffer_handle   <= 8'h00;
		bus_status      <= 8'h00;
		rx_byte         <= 8'h00;
		byte_pos   = 8'h00;
		jitter_on  = 1'b1;
		calm       = 1'b0;
		head_phase = 0;
		sat_done   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (k = 0; k < NUM_DIRECTED; k++)
			send_item(DIRECTED[k].it, DIRECTED[k].pinned, DIRECTED[k].act, DIRECTED[k].lvl);

		// random flows
		n_items = NUM_DIRECTED;
		while (n_items < TOTAL_ITEMS) begin
			if (n_items % 32 == 0)
				jitter_on = ($urandom_range(0, 3) != 0);
			calm = (n_items >= TOTAL_ITEMS - CALM_TAIL);
			if (n_items >= SAT_RUN_AT && !sat_done) begin
				// drain, then one read long enough to pin the byte index at its top
				while (txn_fifo.size() > 0) begin
					send_item(event_item(ST_UNKNOWN), 1'b0, ACT_NONE, 4'd0);
					n_items++;
				end
				it = event_item(8'h00);
				it.op  = OP_ENQUEUE;
				it.rnw = 1'b1;
				it.len = 8'd2;
				send_item(it, 1'b0, ACT_NONE, 4'd0);
				send_item(event_item(ST_START_SENT), 1'b0, ACT_NONE, 4'd0);
				send_item(event_item(ST_SLAR_ACK), 1'b0, ACT_NONE, 4'd0);
				repeat (257)
					send_item(event_item(ST_DATA_RX_ACK), 1'b0, ACT_NONE, 4'd0);
				send_item(event_item(ST_DATA_RX_NACK), 1'b0, ACT_NONE, 4'd0);
				n_items += 261;
				head_phase = 0;
				sat_done = 1'b1;
			end else begin
				it = next_random_item();
				if (it.op == OP_ENQUEUE || txn_fifo.size() > 0)
					n_items++;
				send_item(it, 1'b0, ACT_NONE, 4'd0);
				if (head_changed)
					head_phase = 0;
			end
		end
		req_valid <= 1'b0;

		// let the result stream drain
		while (cmd_expect.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d request transactions (%0d directed), %0d commands compared",
			n_sent, NUM_DIRECTED, n_checked);
		$display("%0d full-queue rejects; one read held its byte index at the top value",
			n_rejects);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
